### hdl/pse_pkg.sv
// Package with character codes and status codes of the postfix stack evaluator.
package pse_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_DIVZERO   = 3'd4;

  typedef logic [31:0] word_t;

endpackage

### hdl/pse_div.sv
// Signed 32-bit restoring divider that truncates toward zero, one quotient bit per cycle.
module pse_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  pse_pkg::word_t  dividend,
  input  pse_pkg::word_t  divisor,
  output logic            done,
  output pse_pkg::word_t  quotient
);

  logic           busy;
  logic [4:0]     cnt;
  logic           neg;
  pse_pkg::word_t rem;
  pse_pkg::word_t quo;
  pse_pkg::word_t dmag;
  logic [32:0]    trial;
  logic [32:0]    diff;

  assign trial    = {rem, quo[31]};
  assign diff     = trial - {1'b0, dmag};
  assign quotient = neg ? (32'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend[31] ? (32'd0 - dividend) : dividend;
      dmag <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg  <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      rem <= diff[32] ? trial[31:0] : diff[31:0];
      quo <= {quo[30:0], ~diff[32]};
    end
  end

endmodule

### hdl/postfix_stack_evaluator.sv
// Top level of the postfix stack evaluator: stack memory, top register and control.
//
// One word on the input channel is one expression character with a flag on
// the last character. Digits push 0 to 9; + - * / pop two operands and push
// the 32-bit wrapping result. One word on the result channel comes after each
// last character and carries the top of stack and a status code.
// For an operator, the left operand is read from the registered read port of
// the stack memory, while the right operand sits in the top register. Division
// waits in its own state for the divider, which gives one quotient bit per
// cycle. A last character passes through a finish state that loads the result
// register, after which the next expression may start.
// The first error is latched and later characters are taken without effect
// until the last one. Reset empties the stack, clears the error and drops
// the result valid; memory contents are not cleared.
// While the receiver stalls, the result word holds; the block keeps taking
// characters and only stops at the next last character until the result
// register is free.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  logic [7:0]         character,
  input  logic               last,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] value,
  output logic [2:0]         status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  pse_pkg::word_t mem [STACK_DEPTH];
  pse_pkg::word_t rd_data;
  pse_pkg::word_t top;
  pse_pkg::word_t alu_res;
  pse_pkg::word_t div_quo;
  logic [1:0]     state;
  logic [CW-1:0]  count;
  logic [2:0]     error;
  logic [7:0]     op;
  logic           last_q;
  logic           accept;
  logic           is_digit;
  logic           is_op;
  logic           mem_we;
  logic           mem_re;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;
  logic           div_start;
  logic           div_done;
  logic [CW-1:0]  count_m1;
  logic [CW-1:0]  count_m2;

  assign char_stall = (state != S_IDLE);
  assign accept     = char_valid & ~char_stall;
  assign is_digit   = (character >= pse_pkg::CHAR_ZERO) && (character <= pse_pkg::CHAR_NINE);
  assign is_op      = (character == pse_pkg::CHAR_PLUS) || (character == pse_pkg::CHAR_MINUS) ||
                      (character == pse_pkg::CHAR_STAR) || (character == pse_pkg::CHAR_SLASH);
  assign count_m1   = count - CW'(1);
  assign count_m2   = count - CW'(2);
  assign waddr      = count_m1[AW-1:0];
  assign raddr      = count_m2[AW-1:0];

  assign mem_we = accept && (error == pse_pkg::ST_OK) && is_digit &&
                  (count < CW'(STACK_DEPTH)) && (count != '0);
  assign mem_re = accept && (error == pse_pkg::ST_OK) && !is_digit && is_op &&
                  (count >= CW'(2));

  assign div_start = (state == S_EXEC) && (op == pse_pkg::CHAR_SLASH) && (top != '0);

  always_comb begin
    unique case (op)
      pse_pkg::CHAR_PLUS:  alu_res = rd_data + top;
      pse_pkg::CHAR_MINUS: alu_res = rd_data - top;
      pse_pkg::CHAR_STAR:  alu_res = rd_data * top;
      default:             alu_res = rd_data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= top;
    end
    if (mem_re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= character;
      last_q <= last;
    end
  end

  pse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_data),
    .divisor  (top),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      error        <= pse_pkg::ST_OK;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_FINISH)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (mem_re) begin
              state <= S_EXEC;
            end else if (last) begin
              state <= S_FINISH;
            end
            if (error == pse_pkg::ST_OK) begin
              if (is_digit) begin
                if (count >= CW'(STACK_DEPTH)) begin
                  error <= pse_pkg::ST_OVERFLOW;
                end else begin
                  top   <= {28'd0, 4'(character - pse_pkg::CHAR_ZERO)};
                  count <= count + CW'(1);
                end
              end else if (!is_op) begin
                error <= pse_pkg::ST_INVALID;
              end else if (count < CW'(2)) begin
                error <= pse_pkg::ST_UNDERFLOW;
              end
            end
          end
        end
        S_EXEC: begin
          if (op == pse_pkg::CHAR_SLASH) begin
            if (top == '0) begin
              error <= pse_pkg::ST_DIVZERO;
              state <= last_q ? S_FINISH : S_IDLE;
            end else begin
              state <= S_DIV;
            end
          end else begin
            top   <= alu_res;
            count <= count_m1;
            state <= last_q ? S_FINISH : S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            top   <= div_quo;
            count <= count_m1;
            state <= last_q ? S_FINISH : S_IDLE;
          end
        end
        S_FINISH: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            if (error != pse_pkg::ST_OK) begin
              status <= error;
              value  <= '0;
            end else if (count == '0) begin
              status <= pse_pkg::ST_UNDERFLOW;
              value  <= '0;
            end else begin
              status <= pse_pkg::ST_OK;
              value  <= $signed(top);
            end
            count <= '0;
            error <= pse_pkg::ST_OK;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/pse_checker.sv
// Port checker for the postfix stack evaluator, bound to the top level.
module pse_checker (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [31:0] value,
  input logic [2:0]         status
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(value) && $stable(status))
    else $error("Result word changed while stalled.");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status <= pse_pkg::ST_DIVZERO))
    else $error("Result status out of range.");

  a_err_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != pse_pkg::ST_OK) |-> (value == 32'sd0))
    else $error("Nonzero value with an error status.");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("Result valid right after reset.");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .value        (value),
  .status       (status)
);
